/* src/fmbq_pkg.sv */
// Types, codes and sizing constants shared by the front/middle/back queue.
`timescale 1ns / 1ps
package fmbq_pkg;

   localparam int Capacity   = 32;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int IndexWidth = $clog2(Capacity);
   localparam int ValueWidth = 32;
   localparam int FillWidth  = 6;

   localparam logic [2:0] ModePushFront  = 3'd0;
   localparam logic [2:0] ModePushMiddle = 3'd1;
   localparam logic [2:0] ModePushBack   = 3'd2;
   localparam logic [2:0] ModePopFront   = 3'd3;
   localparam logic [2:0] ModePopMiddle  = 3'd4;
   localparam logic [2:0] ModePopBack    = 3'd5;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusEmpty = 2'd1;
   localparam logic [1:0] StatusFull  = 2'd2;

   typedef struct packed {
      logic [2:0]                    mode;
      logic signed [ValueWidth-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0]  pop_value;
      logic [1:0]                    status;
      logic [FillWidth-1:0]          fill_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type req;
   } op_type;

endpackage

/* src/front_middle_back_queue.sv */
// Top level of the bounded queue with pushes and pops at front, middle and back.
//
// A request word is presented on req_data with start high; it is taken at any
// rising edge where start is high and busy is low. busy is never raised, so a
// new word may be issued in every cycle, one word per cycle sustained.
// The request is held in an input register while the row of entry cells
// applies it (one shift of at most one place) and the result word is
// registered. rsp_strobe is then high for exactly one cycle with rsp_data.
// The receiver cannot stall: each result is presented once and must be taken
// in that cycle.
// Each request gives one result: the removed value for pops, -1 with status
// empty for a pop from an empty queue, and status full for a push that found
// the queue holding its capacity of entries, in which case the push is
// dropped. fill_count reports the number of entries held after the request.
// A synchronous reset empties the queue and discards any request or result
// in flight; entry contents are not cleared, as no entry is read before it is
// written.
`timescale 1ns / 1ps
module front_middle_back_queue import fmbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    strobe_ff;
   rsp_type rsp_ff;
   op_type  op;
   rsp_type result;

   assign busy     = 1'b0;
   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         req_ff <= req_data;
      end
      if (valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign op.valid = valid_ff;
   assign op.req   = req_ff;

   fmbq_store u_store (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .result (result)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* src/fmbq_store.sv */
// Row of entry cells with the fill count; applies one request per cycle.
`timescale 1ns / 1ps
module fmbq_store import fmbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   output rsp_type result
);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [ValueWidth-1:0] entry_ff [Capacity];
   logic [ValueWidth-1:0] entry_in [Capacity];

   logic                  is_push;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   logic                  do_insert;
   logic                  do_remove;
   logic [CountWidth-1:0] count_less;
   logic [CountWidth-1:0] pos_full;
   logic [IndexWidth-1:0] pos;
   logic [ValueWidth-1:0] read_value;

   assign is_push    = (op.req.mode == ModePushFront) || (op.req.mode == ModePushMiddle) ||
                       (op.req.mode == ModePushBack);
   assign is_pop     = (op.req.mode == ModePopFront) || (op.req.mode == ModePopMiddle) ||
                       (op.req.mode == ModePopBack);
   assign full       = (count_ff == CountWidth'(Capacity));
   assign empty      = (count_ff == '0);
   assign do_insert  = op.valid && is_push && !full;
   assign do_remove  = op.valid && is_pop && !empty;
   assign count_less = count_ff - CountWidth'(1);

   always_comb begin
      unique case (op.req.mode)
         ModePushFront:  pos_full = '0;
         ModePushMiddle: pos_full = count_ff >> 1;
         ModePushBack:   pos_full = count_ff;
         ModePopFront:   pos_full = '0;
         ModePopMiddle:  pos_full = count_less >> 1;
         ModePopBack:    pos_full = count_less;
         default:        pos_full = '0;
      endcase
   end

   assign pos        = pos_full[IndexWidth-1:0];
   assign read_value = entry_ff[pos];

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      always_comb begin
         entry_in[i] = entry_ff[i];
         if (do_insert) begin
            if (IndexWidth'(i) == pos) begin
               entry_in[i] = op.req.push_value;
            end
            if (i > 0) begin
               if (IndexWidth'(i) > pos) begin
                  entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end
         if (do_remove) begin
            if (i < Capacity - 1) begin
               if (IndexWidth'(i) >= pos) begin
                  entry_in[i] = entry_ff[(i < Capacity - 1) ? i + 1 : i];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_remove) begin
         count_in = count_less;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      result.pop_value  = '0;
      result.status     = StatusOk;
      result.fill_count = FillWidth'(count_in);
      if (is_push && full) begin
         result.status = StatusFull;
      end else if (is_pop && empty) begin
         result.status    = StatusEmpty;
         result.pop_value = '1;
      end else if (do_remove) begin
         result.pop_value = $signed(read_value);
      end
   end

endmodule

/* src/fmbq_checker.sv */
// Port-level checks for the queue, bound to the top level.
`timescale 1ns / 1ps
module fmbq_checker import fmbq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Every accepted word yields a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted word produced no result");

   // No result appears without a matching accepted word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   // An empty pop leaves the queue empty and returns all ones.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == StatusEmpty) |->
         (rsp_data.fill_count == '0 && rsp_data.pop_value == '1))
      else $error("empty pop reported wrongly");

   // A rejected push is only reported when the queue is at capacity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == StatusFull) |->
         (rsp_data.fill_count == FillWidth'(Capacity) && rsp_data.pop_value == '0))
      else $error("full push reported below capacity");

endmodule

bind front_middle_back_queue fmbq_checker u_checker (.*);

/* dv/tb_front_middle_back_queue.sv */
// Self-checking testbench for the front/middle/back queue, with a word-level predictor.
`timescale 1ns / 1ps
module tb_front_middle_back_queue;
   import fmbq_pkg::*;

   localparam logic [2:0] ModeSpareLow  = 3'd6;
   localparam logic [2:0] ModeSpareHigh = 3'd7;

   class fmbq_scoreboard;
      logic signed [ValueWidth-1:0] held_values[$];
      rsp_type                      pending_rsps[$];
      int                           errors;

      function void note_request(req_type word);
         rsp_type want;
         int      held;
         held = held_values.size();
         want.pop_value = '0;
         want.status = StatusOk;
         case (word.mode) inside
            ModePushFront, ModePushMiddle, ModePushBack: begin
               if (held >= Capacity) begin
                  want.status = StatusFull;
               end else if (word.mode == ModePushFront) begin
                  held_values.insert(0, word.push_value);
               end else if (word.mode == ModePushMiddle) begin
                  held_values.insert(held / 2, word.push_value);
               end else begin
                  held_values.insert(held, word.push_value);
               end
            end
            ModePopFront, ModePopMiddle, ModePopBack: begin
               if (held == 0) begin
                  want.status = StatusEmpty;
                  want.pop_value = '1;
               end else if (word.mode == ModePopFront) begin
                  want.pop_value = held_values[0];
                  held_values.delete(0);
               end else if (word.mode == ModePopMiddle) begin
                  want.pop_value = held_values[(held - 1) / 2];
                  held_values.delete((held - 1) / 2);
               end else begin
                  want.pop_value = held_values[held - 1];
                  held_values.delete(held - 1);
               end
            end
            default: begin
            end
         endcase
         want.fill_count = FillWidth'(held_values.size());
         pending_rsps.insert(pending_rsps.size(), want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsps.size() == 0) begin
            $display("%0t: result word with none expected, got %p", $time, got);
            errors++;
            return;
         end
         want = pending_rsps[0];
         pending_rsps.delete(0);
         if (got.pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d, got %0d", $time, want.pop_value,
                     got.pop_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d, got %0d", $time, want.fill_count,
                     got.fill_count);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   fmbq_scoreboard tracker = new();
   int             words_sent;

   front_middle_back_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tracker.check_result(rsp_data);
      end
      if (!reset && start && !busy) begin
         tracker.note_request(req_data);
      end
   end

   function automatic int pick_gap(bit no_idle);
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   task automatic issue_word(logic [2:0] mode, logic [ValueWidth-1:0] value, int gap);
      req_type word;
      word.mode = mode;
      word.push_value = value;
      start <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      words_sent++;
   endtask

   function automatic logic [ValueWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          seg_len;
      int          push_pct;
      int          roll;
      bit          no_idle;
      logic [2:0]  mode;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_word(ModePopFront, 32'h1234_5678, 0);
      issue_word(ModePopMiddle, '0, 1);
      issue_word(ModePopBack, '1, 0);
      issue_word(ModePushBack, 32'h7FFF_FFFF, 0);
      issue_word(ModePushFront, 32'h8000_0000, 2);
      issue_word(ModePushMiddle, '0, 0);
      issue_word(ModePushMiddle, '1, 0);
      issue_word(ModePushBack, 32'h5555_5555, 0);
      issue_word(ModePushFront, 32'hAAAA_AAAA, 1);
      issue_word(ModeSpareLow, 32'hDEAD_BEEF, 0);
      issue_word(ModeSpareHigh, 32'h0BAD_F00D, 0);
      issue_word(ModePushMiddle, 32'h0000_0001, 0);
      issue_word(ModePopMiddle, '0, 0);
      issue_word(ModePopFront, '0, 3);
      issue_word(ModePopBack, '0, 0);
      issue_word(ModePopMiddle, '0, 0);
      issue_word(ModePopMiddle, '0, 0);
      issue_word(ModePopFront, '0, 0);
      issue_word(ModePopBack, '0, 0);
      issue_word(ModePopMiddle, '0, 0);

      words_sent = 0;
      while (words_sent < 1700) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: push_pct = 90;
            1: push_pct = 50;
            default: push_pct = 15;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               mode = 3'($urandom_range(ModeSpareLow, ModeSpareHigh));
            end else if ($urandom_range(0, 99) < push_pct) begin
               mode = 3'($urandom_range(ModePushFront, ModePushBack));
            end else begin
               mode = 3'($urandom_range(ModePopFront, ModePopBack));
            end
            issue_word(mode, pick_value(), pick_gap(no_idle));
         end
      end
      start <= 1'b0;

      while (tracker.pending_rsps.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_rsps.size() == 0) begin
         $display("front_middle_back_queue: match");
      end else begin
         $display("front_middle_back_queue: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("front_middle_back_queue: mismatch");
      $finish;
   end

endmodule
